>>> design/vn_pkg.sv
// vector normalize package: field widths, beat structs and count codes
// no dependencies
package vn_pkg;

  localparam int COMP_BITS         = 16;
  localparam int UNIT_BITS         = 16;
  localparam int COUNT_BITS        = 3;
  localparam int NUM_COMP          = 4;
  localparam int DEF_FRACTION_BITS = 14;

  localparam logic [COUNT_BITS-1:0] COUNT_MIN   = 3'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_THREE = 3'd3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 3'd4;

  typedef struct packed {
    logic [COUNT_BITS-1:0]       component_count;
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
    logic signed [COMP_BITS-1:0] comp_w;
  } vn_in_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] unit_x;
    logic signed [UNIT_BITS-1:0] unit_y;
    logic signed [UNIT_BITS-1:0] unit_z;
    logic signed [UNIT_BITS-1:0] unit_w;
    logic                        zero_length;
  } vn_out_t;

endpackage

>>> design/vn_root.sv
// vector normalize root pipeline: largest k with k*k*s <= t, one bit per stage
// depends on nothing but its parameters
module vn_root #(
  parameter int FRACTION_BITS = 14,
  parameter int SUM_BITS      = 34,
  parameter int WIDE_BITS     = 67
) (
  input  logic                       clk_i,
  input  logic [SUM_BITS-1:0]        sum_i,
  input  logic [WIDE_BITS-1:0]       target_i,
  output logic [FRACTION_BITS+1:0]   root_o
);

  localparam int KBits  = FRACTION_BITS + 2;
  localparam int Stages = KBits;

  logic [WIDE_BITS-1:0] rem_q  [Stages];
  logic [WIDE_BITS-1:0] prod_q [Stages];
  logic [WIDE_BITS-1:0] sum_q  [Stages];
  logic [KBits-1:0]     root_q [Stages];

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam int Bit = Stages - 1 - i;
    logic [WIDE_BITS-1:0] rem_in, prod_in, sum_in, delta;
    logic [KBits-1:0]     root_in;

    if (i == 0) begin : g_first
      assign rem_in  = target_i;
      assign prod_in = '0;
      assign sum_in  = WIDE_BITS'(sum_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign prod_in = prod_q[i-1];
      assign sum_in  = sum_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign delta = (prod_in << (Bit + 1)) + (sum_in << (2 * Bit));

    always_ff @(posedge clk_i) begin
      sum_q[i] <= sum_in;
      if (delta <= rem_in) begin
        rem_q[i]  <= rem_in - delta;
        prod_q[i] <= prod_in + (sum_in << Bit);
        root_q[i] <= root_in | (KBits'(1) << Bit);
      end else begin
        rem_q[i]  <= rem_in;
        prod_q[i] <= prod_in;
        root_q[i] <= root_in;
      end
    end
  end

  assign root_o = root_q[Stages-1];

endmodule

>>> design/vector_normalize.sv
// vector normalize top: scales a 2..4 component vector to unit length in Q1.F
// depends on vn_pkg and vn_root
//
//  channel | ports                 | handshake
//  in      | start, busy, in_i     | beat taken when start and not busy
//  out     | done_o, out_o         | one-cycle strobe, no back pressure
//
// one beat per cycle
// the root search resolves one bit of the root per stage
// busy is always low; the pipeline never stalls since the receiver cannot push back
// reset clears only the valid bits, data registers are not reset
module vector_normalize
  import vn_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  vn_in_t  in_i,
  output logic    done_o,
  output vn_out_t out_o
);

  localparam int SqBits   = 2 * COMP_BITS;
  localparam int SumBits  = SqBits + 2;
  localparam int WideBits = 2 * COMP_BITS + 2 * FRACTION_BITS + 7;
  localparam int KBits    = FRACTION_BITS + 2;
  localparam int Latency  = FRACTION_BITS + 5;

  assign busy = 1'b0;

  // stage 1: magnitudes and squares
  logic [COUNT_BITS-1:0]       count;
  logic signed [COMP_BITS-1:0] comp [NUM_COMP];
  logic [COMP_BITS-1:0]        mag  [NUM_COMP];
  logic                        v1_q;
  logic [NUM_COMP-1:0]         neg1_q;
  logic [SqBits-1:0]           sq1_q [NUM_COMP];

  always_comb begin
    count = in_i.component_count;
    if (count < COUNT_MIN) begin
      count = COUNT_MIN;
    end else if (count > COUNT_MAX) begin
      count = COUNT_MAX;
    end
    comp[0] = in_i.comp_x;
    comp[1] = in_i.comp_y;
    comp[2] = (count >= COUNT_THREE) ? in_i.comp_z : '0;
    comp[3] = (count == COUNT_MAX) ? in_i.comp_w : '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      mag[i] = comp[i][COMP_BITS-1] ? COMP_BITS'(~comp[i] + 1'b1) : comp[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_COMP; i++) begin
      neg1_q[i] <= comp[i][COMP_BITS-1];
      sq1_q[i]  <= SqBits'(mag[i]) * SqBits'(mag[i]);
    end
  end

  // stage 2: sum of squares and scaled targets
  logic                v2_q;
  logic [NUM_COMP-1:0] neg2_q;
  logic                zero2_q;
  logic [SumBits-1:0]  sum2_q;
  logic [WideBits-1:0] tgt2_q [NUM_COMP];
  logic [SumBits-1:0]  sum_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      sum_d = sum_d + SumBits'(sq1_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg2_q  <= neg1_q;
    sum2_q  <= sum_d;
    zero2_q <= (sum_d == '0);
    for (int i = 0; i < NUM_COMP; i++) begin
      tgt2_q[i] <= WideBits'(sq1_q[i]) << (2 * FRACTION_BITS + 2);
    end
  end

  // root stages, side band travels alongside
  logic [KBits-1:0]    root [NUM_COMP];
  logic                vs_q    [KBits];
  logic [NUM_COMP-1:0] negs_q  [KBits];
  logic                zeros_q [KBits];

  for (genvar l = 0; l < NUM_COMP; l++) begin : g_lane
    vn_root #(
      .FRACTION_BITS (FRACTION_BITS),
      .SUM_BITS      (SumBits),
      .WIDE_BITS     (WideBits)
    ) u_root (
      .clk_i    (clk_i),
      .sum_i    (sum2_q),
      .target_i (tgt2_q[l]),
      .root_o   (root[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KBits; i++) begin
        vs_q[i] <= 1'b0;
      end
    end else begin
      vs_q[0] <= v2_q;
      for (int i = 1; i < KBits; i++) begin
        vs_q[i] <= vs_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    negs_q[0]  <= neg2_q;
    zeros_q[0] <= zero2_q;
    for (int i = 1; i < KBits; i++) begin
      negs_q[i]  <= negs_q[i-1];
      zeros_q[i] <= zeros_q[i-1];
    end
  end

  // output stage: round to odd-centered unit, apply sign
  logic [KBits:0]           half [NUM_COMP];
  logic [UNIT_BITS-1:0]     unit_d [NUM_COMP];
  logic                     done_q;
  vn_out_t                  out_q;

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      half[i] = ({1'b0, root[i]} + 1'b1) >> 1;
      if (zeros_q[KBits-1]) begin
        unit_d[i] = '0;
      end else if (negs_q[KBits-1][i]) begin
        unit_d[i] = UNIT_BITS'(~half[i] + 1'b1);
      end else begin
        unit_d[i] = UNIT_BITS'(half[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vs_q[KBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.unit_x      <= unit_d[0];
    out_q.unit_y      <= unit_d[1];
    out_q.unit_z      <= unit_d[2];
    out_q.unit_w      <= unit_d[3];
    out_q.zero_length <= zeros_q[KBits-1];
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o)
    else $error("beat lost in pipeline");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.zero_length |-> out_o.unit_x == '0 && out_o.unit_y == '0 &&
      out_o.unit_z == '0 && out_o.unit_w == '0)
    else $error("zero vector gave nonzero unit");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without input beat");

endmodule

>>> tb/tb_vector_normalize.sv
// testbench for vector_normalize: directed table plus random vectors, bursty start
// checks every done_o beat: typed table rows against their table unit, others against an exact integer predictor
// depends on vn_pkg and the vector_normalize rtl
module tb_vector_normalize;
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = DEF_FRACTION_BITS;
  localparam int DRAIN     = FRAC + 25;
  localparam int IDLE_MAX  = 2000;
  localparam int N_RANDOM  = 650;

  typedef struct {
    vn_in_t  vec;
    bit      typed;
    vn_out_t unit;
  } vec_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  vn_in_t  in_i = '0;
  logic    done_o;
  vn_out_t out_o;

  vn_out_t  unit_q[$];
  vec_row_t rows[$];
  bit       taken = 1'b0;
  int       mismatches = 0;
  int       beats_in = 0;
  int       beats_out = 0;
  int       zero_seen = 0;
  int       idle_cycles = 0;

  vector_normalize DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #5 clk_i = ~clk_i;

  // largest n in 0..2^F with (2n-1)^2 * sum <= 4 * mag^2 * 2^(2F)
  function automatic logic [UNIT_BITS-1:0] root_scale(logic [COMP_BITS-1:0] mag,
                                                       logic [127:0] sum);
    logic [127:0] bound, d, lo, hi, mid;
    bound = ({112'd0, mag} * {112'd0, mag}) << (2 * FRAC + 2);
    lo = 0;
    hi = 128'd1 << FRAC;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * sum <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[UNIT_BITS-1:0];
  endfunction

  function automatic vn_out_t normalize(vn_in_t v);
    logic signed [COMP_BITS-1:0] comp[NUM_COMP];
    logic [COMP_BITS-1:0] mag[NUM_COMP];
    logic [UNIT_BITS-1:0] res[NUM_COMP];
    logic [127:0] sum;
    int active;
    bit all_zero;
    vn_out_t r;
    comp = '{v.comp_x, v.comp_y, v.comp_z, v.comp_w};
    active = v.component_count < COUNT_MIN ? COUNT_MIN :
             v.component_count > COUNT_MAX ? COUNT_MAX : v.component_count;
    sum = 0;
    all_zero = 1'b1;
    for (int i = 0; i < NUM_COMP; i++) begin
      mag[i] = comp[i][COMP_BITS-1] ? -comp[i] : comp[i];
      if (i < active) begin
        sum += {112'd0, mag[i]} * {112'd0, mag[i]};
        if (mag[i] != 0) all_zero = 1'b0;
      end
    end
    for (int i = 0; i < NUM_COMP; i++) begin
      res[i] = '0;
      if (!all_zero && i < active) begin
        res[i] = root_scale(mag[i], sum);
        if (comp[i][COMP_BITS-1]) res[i] = -res[i];
      end
    end
    r.unit_x = res[0];
    r.unit_y = res[1];
    r.unit_z = res[2];
    r.unit_w = res[3];
    r.zero_length = all_zero;
    return r;
  endfunction

  function automatic vn_in_t mk_vec(logic [COUNT_BITS-1:0] n, int x, int y, int z, int w);
    vn_in_t v;
    v.component_count = n;
    v.comp_x = COMP_BITS'(x);
    v.comp_y = COMP_BITS'(y);
    v.comp_z = COMP_BITS'(z);
    v.comp_w = COMP_BITS'(w);
    return v;
  endfunction

  function automatic vn_out_t mk_unit(int x, int y, int z, int w, bit zl);
    vn_out_t u;
    u.unit_x = UNIT_BITS'(x);
    u.unit_y = UNIT_BITS'(y);
    u.unit_z = UNIT_BITS'(z);
    u.unit_w = UNIT_BITS'(w);
    u.zero_length = zl;
    return u;
  endfunction

  function automatic logic signed [COMP_BITS-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return COMP_BITS'($urandom_range(0, 15) - 8);
      2:       return COMP_BITS'($urandom_range(0, 511) - 256);
      default: return COMP_BITS'($urandom);
    endcase
  endfunction

  task automatic add_row(vn_in_t v, bit typed = 1'b0, vn_out_t u = '0);
    vec_row_t r;
    r.vec = v;
    r.typed = typed;
    r.unit = typed ? u : normalize(v);
    rows.push_back(r);
  endtask

  // one beat; start stays high while the burst goes on
  task automatic send_beat(vn_in_t v);
    start <= 1'b1;
    in_i  <= v;
    do @(negedge clk_i); while (!taken);
  endtask

  always @(posedge clk_i) begin
    vn_out_t want;
    taken <= start && !busy;
    if (rst_ni) begin
      if (start && !busy) begin
        beats_in++;
        if (rows.size() != 0) begin
          unit_q.push_back(rows[0].unit);
          rows.pop_front();
        end else begin
          unit_q.push_back(normalize(in_i));
        end
      end
      if (done_o) begin
        beats_out++;
        if (out_o.zero_length) zero_seen++;
        if (unit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %p", out_o);
        end else begin
          want = unit_q.pop_front();
          if (out_o.unit_x !== want.unit_x || out_o.unit_y !== want.unit_y ||
              out_o.unit_z !== want.unit_z || out_o.unit_w !== want.unit_w ||
              out_o.zero_length !== want.zero_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, out_o);
          end
        end
      end
      idle_cycles = (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("watchdog: no beat for %0d cycles", IDLE_MAX);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int burst, sent, n;
    vn_in_t v;
    add_row(mk_vec(COUNT_MIN, 0, 0, 0, 0), 1'b1, mk_unit(0, 0, 0, 0, 1));
    add_row(mk_vec(COUNT_MAX, 0, 0, 0, 0), 1'b1, mk_unit(0, 0, 0, 0, 1));
    add_row(mk_vec(COUNT_MIN, 0, 0, 77, -5), 1'b1, mk_unit(0, 0, 0, 0, 1));
    add_row(mk_vec(COUNT_MIN, 1, 0, 0, 0), 1'b1, mk_unit(16384, 0, 0, 0, 0));
    add_row(mk_vec(COUNT_MIN, -32768, 0, 0, 0), 1'b1, mk_unit(-16384, 0, 0, 0, 0));
    add_row(mk_vec(COUNT_THREE, 0, 0, 32767, 0), 1'b1, mk_unit(0, 0, 16384, 0, 0));
    add_row(mk_vec(COUNT_MAX, 0, 0, 0, -1), 1'b1, mk_unit(0, 0, 0, -16384, 0));
    add_row(mk_vec(COUNT_MAX, -32768, -32768, -32768, -32768), 1'b1,
            mk_unit(-8192, -8192, -8192, -8192, 0));
    add_row(mk_vec(COUNT_MAX, 32767, 32767, 32767, 32767), 1'b1,
            mk_unit(8192, 8192, 8192, 8192, 0));
    add_row(mk_vec(3'd0, 3, 4, 99, 99), 1'b1, mk_unit(9830, 13107, 0, 0, 0));
    add_row(mk_vec(3'd1, -3, 4, 99, 99), 1'b1, mk_unit(-9830, 13107, 0, 0, 0));
    add_row(mk_vec(3'd7, 0, 0, 0, 5));
    add_row(mk_vec(3'd5, 1, 2, 3, 4));
    add_row(mk_vec(3'd6, -32768, 32767, 1, -1));
    add_row(mk_vec(COUNT_THREE, 1, 1, 1, 32767));
    add_row(mk_vec(COUNT_MIN, 32767, -32768, 0, 0));
    add_row(mk_vec(COUNT_MIN, 1, 1, 0, 0));
    add_row(mk_vec(COUNT_THREE, 2, -1, 2, 0));
    add_row(mk_vec(COUNT_MAX, 1, -1, 1, -1));
    add_row(mk_vec(COUNT_MAX, 12345, -23456, 345, -4567));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    sent = 0;
    n = rows.size() + N_RANDOM;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < n; k++) begin
        if (sent < 20) v = rows[0].vec;
        else begin
          v.component_count = COUNT_BITS'(($urandom_range(0, 9) == 0) ?
                                          $urandom : $urandom_range(2, 4));
          v.comp_x = rand_comp();
          v.comp_y = rand_comp();
          v.comp_z = rand_comp();
          v.comp_w = rand_comp();
        end
        send_beat(v);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk_i);
      end
    end
    start <= 1'b0;

    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("%0d vectors in, %0d results out, %0d zero-length, %0d mismatches",
             beats_in, beats_out, zero_seen, mismatches);
    if (mismatches == 0 && unit_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> vector_normalize.f
design/vn_pkg.sv
design/vn_root.sv
design/vector_normalize.sv
tb/tb_vector_normalize.sv
